// ===== rtl/hshm_pkg.sv =====
// ----------------------------------------------------------------------------
// hshm_pkg
// Types, register codes and helpers shared by the sample health monitor.
// ----------------------------------------------------------------------------
package hshm_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CFG_IDX_W = 3;

    // a zero reference time means "never"
    localparam logic [TIME_W-1:0] NEVER_AGE = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        HEALTH_OK   = 2'd0,
        HEALTH_WARN = 2'd1,
        HEALTH_ERR  = 2'd2,
        HEALTH_HARD = 2'd3
    } health_t;

    typedef enum logic [2:0] {
        ACT_RAW      = 3'd0,
        ACT_BACKDATE = 3'd1,
        ACT_VALID    = 3'd2,
        ACT_UPDATE   = 3'd3,
        ACT_POP      = 3'd4,
        ACT_ARM      = 3'd5
    } action_t;

    localparam logic [CFG_IDX_W-1:0] CFG_WARN_AFTER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_AFTER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HARD_AFTER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OK_STABLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_MAXAGE = 3'd4;

    typedef struct packed {
        logic [CFG_W-1:0] warn_after_ms;
        logic [CFG_W-1:0] error_after_ms;
        logic [CFG_W-1:0] hard_after_ms;
        logic [CFG_W-1:0] ok_stable_ms;
        logic [CFG_W-1:0] last_valid_max_age_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        warn_after_ms:         32'd500,
        error_after_ms:        32'd1500,
        hard_after_ms:         32'd5000,
        ok_stable_ms:          32'd1000,
        last_valid_max_age_ms: 32'd10000
    };

    typedef struct packed {
        health_t             health;
        logic [TIME_W-1:0]   last_raw_time;
        logic [TIME_W-1:0]   last_valid_time;
        logic [VALUE_W-1:0]  last_valid_reading;
        logic                had_valid;
        logic [TIME_W-1:0]   good_window_start;
        logic                beep_pending;
    } state_t;

    localparam state_t STATE_RESET = '{
        health:             HEALTH_OK,
        last_raw_time:      '0,
        last_valid_time:    '0,
        last_valid_reading: '0,
        had_valid:          1'b0,
        good_window_start:  '0,
        beep_pending:       1'b0
    };

    typedef struct packed {
        health_t            health;
        logic               beep_popped;
        logic               can_show_last;
        logic [VALUE_W-1:0] last_valid_value;
    } result_t;

    // elapsed time from reference to now, saturating at zero when time runs back; a zero reference reads as never
    function automatic logic [TIME_W-1:0] elapsed(
        input logic [TIME_W-1:0] now,
        input logic [TIME_W-1:0] ref_time
    );
        logic [TIME_W-1:0] diff;
        diff = now - ref_time;
        if (ref_time == '0)
            return NEVER_AGE;
        else if (now >= ref_time)
            return diff;
        else
            return '0;
    endfunction

endpackage

// ===== rtl/hshm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// hshm_cfg_regs
// Threshold register file, written through the plain configuration port.
// ----------------------------------------------------------------------------
module hshm_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [hshm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hshm_pkg::CFG_W-1:0]         cfg_data,
    output hshm_pkg::cfg_t                     cfg
);

    hshm_pkg::cfg_t cfg_reg;
    hshm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                hshm_pkg::CFG_WARN_AFTER:   cfg_next.warn_after_ms         = cfg_data;
                hshm_pkg::CFG_ERROR_AFTER:  cfg_next.error_after_ms        = cfg_data;
                hshm_pkg::CFG_HARD_AFTER:   cfg_next.hard_after_ms         = cfg_data;
                hshm_pkg::CFG_OK_STABLE:    cfg_next.ok_stable_ms          = cfg_data;
                hshm_pkg::CFG_VALID_MAXAGE: cfg_next.last_valid_max_age_ms = cfg_data;
                default:
                begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= hshm_pkg::CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/hshm_eval.sv =====
// ----------------------------------------------------------------------------
// hshm_eval
// Single-pass event evaluation: next monitor state and result fields.
// ----------------------------------------------------------------------------
module hshm_eval (
    input  hshm_pkg::cfg_t                     cfg,
    input  hshm_pkg::state_t                   cur,
    input  logic [2:0]                         action,
    input  logic [hshm_pkg::TIME_W-1:0]        time_ms,
    input  logic [hshm_pkg::VALUE_W-1:0]       grams_value,
    output hshm_pkg::state_t                   nxt,
    output hshm_pkg::result_t                  result
);

    logic [hshm_pkg::TIME_W-1:0] gap;
    logic [hshm_pkg::TIME_W-1:0] win_start;
    logic [hshm_pkg::TIME_W-1:0] win_age;
    logic [hshm_pkg::TIME_W-1:0] valid_age;
    hshm_pkg::health_t           want;
    logic                        was_err;
    logic                        is_err;
    logic                        popped;

    // grading of the raw sample gap, computed in parallel with the decode
    always_comb
    begin
        gap       = hshm_pkg::elapsed(time_ms, cur.last_raw_time);
        win_start = (cur.good_window_start == '0) ? time_ms : cur.good_window_start;
        win_age   = hshm_pkg::elapsed(time_ms, win_start);
        if (gap >= cfg.error_after_ms)
            want = (gap >= cfg.hard_after_ms || !cur.had_valid)
                 ? hshm_pkg::HEALTH_HARD : hshm_pkg::HEALTH_ERR;
        else if (gap >= cfg.warn_after_ms)
            want = hshm_pkg::HEALTH_WARN;
        else
            want = hshm_pkg::HEALTH_OK;
    end

    always_comb
    begin
        nxt     = cur;
        popped  = 1'b0;
        was_err = 1'b0;
        is_err  = 1'b0;
        unique case (hshm_pkg::action_t'(action))
            hshm_pkg::ACT_RAW:
                nxt.last_raw_time = time_ms;
            hshm_pkg::ACT_BACKDATE:
            begin
                // only ever moves the raw time earlier, or sets it when none is stored
                if (time_ms != '0 &&
                    (cur.last_raw_time == '0 || time_ms < cur.last_raw_time))
                    nxt.last_raw_time = time_ms;
            end
            hshm_pkg::ACT_VALID:
            begin
                nxt.last_valid_time    = time_ms;
                nxt.last_valid_reading = grams_value;
                nxt.had_valid          = 1'b1;
            end
            hshm_pkg::ACT_UPDATE:
            begin
                if (want == hshm_pkg::HEALTH_OK && cur.health != hshm_pkg::HEALTH_OK)
                begin
                    nxt.good_window_start = win_start;
                    if (win_age >= cfg.ok_stable_ms)
                    begin
                        nxt.health            = hshm_pkg::HEALTH_OK;
                        nxt.good_window_start = '0;
                    end
                end
                else
                begin
                    if (want != hshm_pkg::HEALTH_OK)
                        nxt.good_window_start = '0;
                    nxt.health = want;
                end
                was_err = (cur.health == hshm_pkg::HEALTH_ERR ||
                           cur.health == hshm_pkg::HEALTH_HARD);
                is_err  = (nxt.health == hshm_pkg::HEALTH_ERR ||
                           nxt.health == hshm_pkg::HEALTH_HARD);
                if (!was_err && is_err)
                    nxt.beep_pending = 1'b1;
                if (nxt.health == hshm_pkg::HEALTH_OK)
                    nxt.beep_pending = 1'b0;
            end
            hshm_pkg::ACT_POP:
            begin
                if (cur.beep_pending)
                begin
                    nxt.beep_pending = 1'b0;
                    popped           = 1'b1;
                end
            end
            hshm_pkg::ACT_ARM:
            begin
                nxt               = hshm_pkg::STATE_RESET;
                nxt.last_raw_time = time_ms;
            end
            default:
            begin
                // unused codes leave the state alone
            end
        endcase
    end

    always_comb
    begin
        valid_age                = hshm_pkg::elapsed(time_ms, nxt.last_valid_time);
        result.health            = nxt.health;
        result.beep_popped       = popped;
        result.can_show_last     = (nxt.health == hshm_pkg::HEALTH_ERR) && nxt.had_valid &&
                                   (valid_age <= cfg.last_valid_max_age_ms);
        result.last_valid_value  = nxt.last_valid_reading;
    end

endmodule

// ===== rtl/sensor_sample_health_monitor.sv =====
// ----------------------------------------------------------------------------
// sensor_sample_health_monitor
// Watchdog that grades the gap between raw sensor samples.
// ----------------------------------------------------------------------------
// Takes one event per clock cycle, back to back, and shows the result of an
// event on the output ports once it has passed the input register, the
// evaluation and the result register. The input stalls only while both
// the input register and the result register are full and the output is
// stalled. The rate is set by the monitor state, which is read and rewritten
// by the combinational evaluation logic for every event.
// Configuration writes take effect at the next clock edge.
module sensor_sample_health_monitor (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [hshm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hshm_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [2:0]                         action,
    input  logic [31:0]                        time_ms,
    input  logic signed [31:0]                 grams_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         health_state,
    output logic                               beep_popped,
    output logic                               can_show_last,
    output logic signed [31:0]                 last_valid_value
);

    hshm_pkg::cfg_t    cfg;
    hshm_pkg::state_t  state_reg;
    hshm_pkg::state_t  state_next;
    hshm_pkg::result_t result_next;
    hshm_pkg::result_t result_reg;

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic [2:0]                    in_action_reg;
    logic [hshm_pkg::TIME_W-1:0]   in_time_reg;
    logic [hshm_pkg::VALUE_W-1:0]  in_grams_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_free;
    logic                          advance;
    logic                          in_take;

    hshm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hshm_eval u_eval (
        .cfg         (cfg),
        .cur         (state_reg),
        .action      (in_action_reg),
        .time_ms     (in_time_reg),
        .grams_value (in_grams_reg),
        .nxt         (state_next),
        .result      (result_next)
    );

    // result register empties or drains this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= hshm_pkg::STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_action_reg <= action;
            in_time_reg   <= time_ms;
            in_grams_reg  <= grams_value;
        end
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid        = out_valid_reg;
    assign health_state     = result_reg.health;
    assign beep_popped      = result_reg.beep_popped;
    assign can_show_last    = result_reg.can_show_last;
    assign last_valid_value = result_reg.last_valid_value;

endmodule

// ===== rtl/hshm_checker.sv =====
// ----------------------------------------------------------------------------
// hshm_checker
// Port-level checks for the sample health monitor, bound to the top level.
// ----------------------------------------------------------------------------
module hshm_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_stall,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [1:0]                         health_state,
    input  logic                               beep_popped,
    input  logic                               can_show_last,
    input  logic signed [31:0]                 last_valid_value
);

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(health_state) &&
        $stable(beep_popped) && $stable(can_show_last) && $stable(last_valid_value))
        else $error("result changed while stalled");

    // input back-pressure only comes from a full, stalled result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // last value is only offered in soft error
    a_show_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && can_show_last |-> health_state == hshm_pkg::HEALTH_ERR)
        else $error("show-last outside soft error");

    // a pending beep never survives a return to ok
    a_beep_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && beep_popped |-> health_state != hshm_pkg::HEALTH_OK)
        else $error("beep popped while healthy");

endmodule

bind sensor_sample_health_monitor hshm_checker u_hshm_checker (.*);

// ===== tb/health_monitor_checker.sv =====
// ----------------------------------------------------------------------------
// health_monitor_checker
// Predicts and checks every result of the sample health monitor.
// ----------------------------------------------------------------------------
// Watches the configuration port and both channels. Each accepted input
// transaction is run through a local copy of the monitor state to form the
// expected result, which is queued and compared field by field against the
// next accepted output transaction.
module health_monitor_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [hshm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hshm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [2:0]                     action,
    input  logic [31:0]                    time_ms,
    input  logic signed [31:0]             grams_value,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [1:0]                     health_state,
    input  logic                           beep_popped,
    input  logic                           can_show_last,
    input  logic signed [31:0]             last_valid_value,
    output int unsigned                    mismatches,
    output int unsigned                    pending
);

    import hshm_pkg::*;

    cfg_t        limits;
    health_t     health;
    logic [31:0] raw_t;
    logic [31:0] valid_t;
    logic [31:0] window_t;
    logic [31:0] held_value;
    logic        seen_valid;
    logic        beep;

    result_t     expected_q[$];

    // zero reference reads as never seen
    function automatic logic [31:0] age_ms(input logic [31:0] now, input logic [31:0] since);
        if (since == '0)
            return NEVER_AGE;
        if (now < since)
            return '0;
        return now - since;
    endfunction

    task automatic clear_state();
        health     = HEALTH_OK;
        raw_t      = '0;
        valid_t    = '0;
        window_t   = '0;
        held_value = '0;
        seen_valid = 1'b0;
        beep       = 1'b0;
    endtask

    task automatic grade_gap(input logic [31:0] now);
        health_t     prev;
        health_t     goal;
        logic [31:0] gap;
        prev = health;
        gap  = age_ms(now, raw_t);
        if (gap >= limits.error_after_ms)
        begin
            if (gap >= limits.hard_after_ms || !seen_valid)
                goal = HEALTH_HARD;
            else
                goal = HEALTH_ERR;
        end
        else if (gap >= limits.warn_after_ms)
            goal = HEALTH_WARN;
        else
            goal = HEALTH_OK;

        // recovery only after a stable good window
        if (goal == HEALTH_OK && health != HEALTH_OK)
        begin
            if (window_t == '0)
                window_t = now;
            if (age_ms(now, window_t) >= limits.ok_stable_ms)
            begin
                health   = HEALTH_OK;
                window_t = '0;
            end
        end
        else
        begin
            if (goal != HEALTH_OK)
                window_t = '0;
            health = goal;
        end

        if (!(prev == HEALTH_ERR || prev == HEALTH_HARD) &&
            (health == HEALTH_ERR || health == HEALTH_HARD))
            beep = 1'b1;
        if (health == HEALTH_OK)
            beep = 1'b0;
    endtask

    task automatic apply_event(input logic [2:0] act, input logic [31:0] t,
                               input logic [31:0] g, output result_t res);
        res.beep_popped = 1'b0;
        case (act)
            ACT_RAW:
                raw_t = t;
            ACT_BACKDATE:
                if (t != '0 && (raw_t == '0 || t < raw_t))
                    raw_t = t;
            ACT_VALID:
            begin
                valid_t    = t;
                held_value = g;
                seen_valid = 1'b1;
            end
            ACT_UPDATE:
                grade_gap(t);
            ACT_POP:
                if (beep)
                begin
                    beep            = 1'b0;
                    res.beep_popped = 1'b1;
                end
            ACT_ARM:
            begin
                clear_state();
                raw_t = t;
            end
            default:
                ;
        endcase
        res.health           = health;
        res.can_show_last    = (health == HEALTH_ERR) && seen_valid &&
                               (age_ms(t, valid_t) <= limits.last_valid_max_age_ms);
        res.last_valid_value = held_value;
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        // keep the log short when the block is badly broken
        if (mismatches < 50)
            $display("%0t checker: %s got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_result();
        result_t want;
        if (expected_q.size() == 0)
        begin
            report("result with no transaction waiting", 32'(health_state), '0);
            return;
        end
        want = expected_q.pop_front();
        if (health_state !== want.health)
            report("health_state", 32'(health_state), 32'(want.health));
        if (beep_popped !== want.beep_popped)
            report("beep_popped", 32'(beep_popped), 32'(want.beep_popped));
        if (can_show_last !== want.can_show_last)
            report("can_show_last", 32'(can_show_last), 32'(want.can_show_last));
        if (last_valid_value !== want.last_valid_value)
            report("last_valid_value", last_valid_value, want.last_valid_value);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t res;
        if (!rst_n)
        begin
            limits = CFG_RESET;
            clear_state();
            expected_q.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_WARN_AFTER:   limits.warn_after_ms         = cfg_data;
                    CFG_ERROR_AFTER:  limits.error_after_ms        = cfg_data;
                    CFG_HARD_AFTER:   limits.hard_after_ms         = cfg_data;
                    CFG_OK_STABLE:    limits.ok_stable_ms          = cfg_data;
                    CFG_VALID_MAXAGE: limits.last_valid_max_age_ms = cfg_data;
                    default:          ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                apply_event(action, time_ms, grams_value, res);
                expected_q.push_back(res);
            end
            pending = expected_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the sensor sample health monitor.
// ----------------------------------------------------------------------------
// A directed sequence walks the corner cases under the reset thresholds, then
// randomised event streams on a moving millisecond clock run under several
// threshold settings, zero and all-ones among them. Both channels idle in
// random bursts; one phase holds the output off long enough to back up the
// input. Checking is done by health_monitor_checker and the bound hshm_checker.
module tb;

    import hshm_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam logic [2:0]  ACT_SPARE_LO = 3'd6;
    localparam logic [2:0]  ACT_SPARE_HI = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [2:0]           action;
    logic [31:0]          time_ms;
    logic signed [31:0]   grams_value;
    logic                 out_valid;
    logic                 out_stall;
    logic [1:0]           health_state;
    logic                 beep_popped;
    logic                 can_show_last;
    logic signed [31:0]   last_valid_value;

    int unsigned          mismatches;
    int unsigned          pending;

    logic [31:0]          clock_ms;
    bit                   tx_quiet;
    bit                   rx_quiet;
    bit                   rx_long_hold;

    sensor_sample_health_monitor u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .time_ms          (time_ms),
        .grams_value      (grams_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .health_state     (health_state),
        .beep_popped      (beep_popped),
        .can_show_last    (can_show_last),
        .last_valid_value (last_valid_value)
    );

    health_monitor_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .time_ms          (time_ms),
        .grams_value      (grams_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .health_state     (health_state),
        .beep_popped      (beep_popped),
        .can_show_last    (can_show_last),
        .last_valid_value (last_valid_value),
        .mismatches       (mismatches),
        .pending          (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    task automatic send_event(input logic [2:0] act, input logic [31:0] t,
                              input logic [31:0] g);
        @(negedge clk);
        in_valid    <= 1'b1;
        action      <= act;
        time_ms     <= t;
        grams_value <= g;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic idle_for(input int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // stop sending and let every outstanding transaction come back
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic load_config(input cfg_t c);
        write_reg(CFG_WARN_AFTER, c.warn_after_ms);
        write_reg(CFG_ERROR_AFTER, c.error_after_ms);
        write_reg(CFG_HARD_AFTER, c.hard_after_ms);
        write_reg(CFG_OK_STABLE, c.ok_stable_ms);
        write_reg(CFG_VALID_MAXAGE, c.last_valid_max_age_ms);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic cfg_t limits_of(input logic [31:0] w, input logic [31:0] e,
                                       input logic [31:0] h, input logic [31:0] s,
                                       input logic [31:0] a);
        cfg_t c;
        c.warn_after_ms         = w;
        c.error_after_ms        = e;
        c.hard_after_ms         = h;
        c.ok_stable_ms          = s;
        c.last_valid_max_age_ms = a;
        return c;
    endfunction

    // mostly plausible event streams on a clock that moves forward by up to span, and now and then back by up to 50
    task automatic random_event(input int unsigned span);
        int unsigned pick;
        logic [2:0]  act;
        logic [31:0] t;
        logic [31:0] g;
        pick = $urandom_range(0, 99);
        g    = $urandom();
        if (pick < 3)
            clock_ms = clock_ms - $urandom_range(1, 50);
        else
            clock_ms = clock_ms + $urandom_range(0, span);
        t = clock_ms;
        if (pick < 25)
            act = ACT_RAW;
        else if (pick < 40)
            act = ACT_VALID;
        else if (pick < 70)
            act = ACT_UPDATE;
        else if (pick < 80)
            act = ACT_POP;
        else if (pick < 86)
        begin
            act = ACT_BACKDATE;
            t   = clock_ms - $urandom_range(0, span);
        end
        else if (pick < 89)
            act = ACT_ARM;
        else if (pick < 91)
            act = pick[0] ? ACT_SPARE_HI : ACT_SPARE_LO;
        else
        begin
            // noise: any code at any time
            act = 3'($urandom_range(0, 7));
            t   = $urandom();
        end
        if (!tx_quiet && $urandom_range(0, 4) == 0)
            idle_for($urandom_range(1, 11));
        send_event(act, t, g);
    endtask

    task automatic run_phase(input cfg_t c, input int unsigned span,
                             input int unsigned count, input bit long_hold);
        settle();
        load_config(c);
        if ($urandom_range(0, 3) == 0)
            clock_ms = $urandom();
        else
            clock_ms = $urandom_range(1, 5000);
        if (long_hold)
            rx_long_hold = 1'b1;
        repeat (count) random_event(span);
    endtask

    initial
    begin : stimulus
        logic [31:0] w;
        logic [31:0] e;
        logic [31:0] h;
        in_valid     = 1'b0;
        action       = ACT_RAW;
        time_ms      = '0;
        grams_value  = '0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_WARN_AFTER;
        cfg_data     = '0;
        clock_ms     = '0;
        tx_quiet     = 1'b0;
        rx_quiet     = 1'b0;
        rx_long_hold = 1'b0;
        rst_n        = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // corner cases under the reset thresholds
        send_event(ACT_UPDATE, 32'd100, '0);          // never sampled, no reading
        send_event(ACT_POP, 32'd110, '0);
        send_event(ACT_POP, 32'd120, '0);
        send_event(ACT_RAW, 32'd1000, '0);
        send_event(ACT_BACKDATE, 32'd0, '0);          // zero backdate ignored
        send_event(ACT_BACKDATE, 32'd2000, '0);       // later than stored, ignored
        send_event(ACT_BACKDATE, 32'd900, '0);
        send_event(ACT_VALID, 32'd0, 32'h8000_0000);  // reading at time zero
        send_event(ACT_UPDATE, 32'd2500, '0);
        send_event(ACT_VALID, 32'd2500, 32'h7FFF_FFFF);
        send_event(ACT_UPDATE, 32'd2600, '0);
        send_event(ACT_POP, 32'd2600, '0);
        send_event(ACT_RAW, 32'd2600, '0);
        send_event(ACT_UPDATE, 32'd2700, '0);
        send_event(ACT_RAW, 32'd3650, '0);
        send_event(ACT_UPDATE, 32'd3700, '0);
        send_event(ACT_SPARE_LO, 32'd4000, 32'h1234_5678);
        send_event(ACT_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(ACT_UPDATE, 32'hFFFF_FFFF, '0);
        send_event(ACT_UPDATE, 32'd5, '0);            // time ran backwards
        send_event(ACT_ARM, 32'd0, '0);
        send_event(ACT_UPDATE, 32'd0, '0);
        send_event(ACT_BACKDATE, 32'd40, '0);         // stored raw time is never, so it takes
        send_event(ACT_UPDATE, 32'd0, '0);            // good window opened at zero
        send_event(ACT_POP, 32'd0, '0);

        run_phase(limits_of(32'd100, 32'd300, 32'd800, 32'd200, 32'd400), 600, 200, 1'b1);
        run_phase(limits_of('0, '0, '0, '0, '0), 300, 120, 1'b0);
        run_phase(limits_of('1, '1, '1, '1, '1), 3000, 120, 1'b0);

        w = $urandom_range(0, 2000);
        e = w + $urandom_range(0, 2000);
        h = e + $urandom_range(0, 4000);
        run_phase(limits_of(w, e, h, $urandom_range(0, 2000), $urandom_range(0, 5000)),
                  h / 2 + 100, 200, 1'b0);
        // thresholds in no particular order
        run_phase(limits_of($urandom_range(0, 3000), $urandom_range(0, 3000),
                            $urandom_range(0, 3000), $urandom_range(0, 3000),
                            $urandom_range(0, 3000)), 2000, 150, 1'b0);
        run_phase(CFG_RESET, 2500, 150, 1'b0);

        // last stretch runs flat out on both sides
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        run_phase(limits_of(32'd50, 32'd150, 32'd400, 32'd100, 32'd300), 300, 150, 1'b0);

        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_long_hold)
            begin
                // long hold so the block backs up and stalls its input
                out_stall <= 1'b1;
                repeat (79) @(negedge clk);
                rx_long_hold = 1'b0;
            end
            else if (!rx_quiet && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(0, 10)) @(negedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: errors");
        $finish;
    end

endmodule
